FILE: hdl/i2cmbe_pkg.sv
// Package for the I2C master byte engine: request codes, field widths,
// register indexes and the queue entry type. No dependencies.
package i2cmbe_pkg;

  localparam logic [2:0] REQ_NONE  = 3'd0;
  localparam logic [2:0] REQ_START = 3'd1;
  localparam logic [2:0] REQ_STOP  = 3'd2;
  localparam logic [2:0] REQ_WRITE = 3'd3;
  localparam logic [2:0] REQ_RDACK = 3'd4;
  localparam logic [2:0] REQ_RDNAK = 3'd5;

  localparam logic [1:0] REG_TPU     = 2'd0;
  localparam logic [1:0] REG_SPEED   = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  localparam logic [7:0] MSB_MASK = 8'h80;

  // One tick as classified by the front part.
  typedef struct packed {
    logic       cmd_start;
    logic       cmd_stop;
    logic       cmd_write;
    logic       cmd_read;
    logic       read_ack;
    logic [7:0] tx_byte;
    logic       sda_sample;
  } tick_t;

  // Result of one tick.
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } res_t;

endpackage

FILE: hdl/i2c_master_byte_engine.sv
// Top level of the I2C master byte engine: front decoder, tick queue and
// bit engine back part. Depends on i2cmbe_pkg and the i2cmbe_* modules.
//
// Each input transfer is one system clock tick of the engine: it carries a
// request code, a byte to send and the sampled SDA level, and it yields
// exactly one result transfer with the SCL/SDA drive and status after that
// tick. One tick is taken per clock cycle while the tick queue has room;
// each accepted tick passes through a two-entry tick queue and then a
// registered output with a skid entry, so either side may stall alone.
// Requests are honored only while the engine is idle. Configuration
// writes (0 ticks_per_us, 1 speed_units, 2 ack_timeout) are taken every
// cycle and must only be issued while the engine is idle.
module i2c_master_byte_engine import i2cmbe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: [2:0] req_type, [10:3] tx_byte, [11] sda_sample, rest zero.
  input  logic [15:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: [0] scl_level, [1] sda_level, [2] sda_enable, [3] busy_res,
  // [4] done_res, [12:5] rx_byte, [13] ack_failed, rest zero.
  output logic [15:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  logic [9:0] ticks_per_us;
  logic [7:0] speed_units;
  logic [7:0] ack_timeout;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_us <= 10'd50;
      speed_units  <= 8'd2;
      ack_timeout  <= 8'd250;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TPU:     ticks_per_us <= cfg_data;
        REG_SPEED:   speed_units  <= cfg_data[7:0];
        REG_TIMEOUT: ack_timeout  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  tick_t dec_tick, q_tick;
  logic  q_valid, q_ready;
  res_t  res;

  i2cmbe_front u_front (
    .req_type(s_tdata[2:0]), .tx_byte(s_tdata[10:3]), .sda_sample(s_tdata[11]),
    .tick(dec_tick)
  );

  i2cmbe_fifo u_fifo (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .in_data(dec_tick), .out_valid(q_valid), .out_ready(q_ready), .out_data(q_tick)
  );

  i2cmbe_back u_back (
    .clk(clk), .rst(rst), .ticks_per_us(ticks_per_us), .speed_units(speed_units),
    .ack_timeout(ack_timeout), .in_valid(q_valid), .in_ready(q_ready),
    .in_data(q_tick), .out_valid(m_tvalid), .out_ready(m_tready), .out_data(res)
  );

  assign m_tdata = {2'b00, res.ack_failed, res.rx_byte, res.done_res, res.busy_res,
                    res.sda_enable, res.sda_level, res.scl_level};
endmodule

FILE: hdl/i2cmbe_front.sv
// Front part: decodes the request code of each incoming tick.
// Depends on i2cmbe_pkg.
module i2cmbe_front import i2cmbe_pkg::*; (
  input  logic [2:0] req_type,
  input  logic [7:0] tx_byte,
  input  logic       sda_sample,
  output tick_t      tick
);
  always_comb begin
    tick.cmd_start  = (req_type == REQ_START);
    tick.cmd_stop   = (req_type == REQ_STOP);
    tick.cmd_write  = (req_type == REQ_WRITE);
    tick.cmd_read   = (req_type == REQ_RDACK) || (req_type == REQ_RDNAK);
    tick.read_ack   = (req_type == REQ_RDACK);
    tick.tx_byte    = tx_byte;
    tick.sda_sample = sda_sample;
  end
endmodule

FILE: hdl/i2cmbe_fifo.sv
// Two-entry queue between the front and back parts.
// Depends on i2cmbe_pkg.
module i2cmbe_fifo import i2cmbe_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  tick_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output tick_t out_data
);
  tick_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_data;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: hdl/i2cmbe_back.sv
// Back part: the bit engine state machine plus a one-entry output register
// with skid. Depends on i2cmbe_pkg.
module i2cmbe_back import i2cmbe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [9:0] ticks_per_us,
  input  logic [7:0] speed_units,
  input  logic [7:0] ack_timeout,
  input  logic       in_valid,
  output logic       in_ready,
  input  tick_t      in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_data
);
  typedef enum logic [3:0] {
    PH_IDLE, PH_START_A, PH_START_B, PH_STOP_A, PH_STOP_B, PH_W_LOW, PH_W_HIGH,
    PH_W_TAIL, PH_ACK_A, PH_ACK_B, PH_ACK_POLL, PH_R_LOW, PH_R_HIGH,
    PH_RA_LOW, PH_RA_HIGH
  } phase_t;

  phase_t     phase, phase_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [9:0] unit_count, unit_count_next;
  logic [8:0] delay_count, delay_count_next;
  logic [7:0] poll_count, poll_count_next;
  logic       scl_reg, scl_reg_next, sda_reg, sda_reg_next;
  logic       read_ack_mode, read_ack_mode_next;
  logic       fail_flag, fail_flag_next;
  logic       sda_oe, sda_oe_next;
  logic [7:0] rx_hold, rx_hold_next;
  logic       done;

  logic [9:0] tpu;
  logic [8:0] s1, s2, units;
  logic [9:0] uc_inc;
  logic [8:0] dc_inc;
  logic       elapsed;
  logic       step;
  res_t       res;
  logic [3:0] bc_inc;
  logic [7:0] sh_rd;

  assign tpu    = (ticks_per_us == 10'd0) ? 10'd1 : ticks_per_us;
  assign s1     = (speed_units == 8'd0) ? 9'd1 : {1'b0, speed_units};
  assign s2     = {s1[7:0], 1'b0};
  assign uc_inc = unit_count + 10'd1;
  assign dc_inc = delay_count + 9'd1;
  assign bc_inc = bit_count + 4'd1;
  assign sh_rd  = {shift_reg[6:0], in_data.sda_sample};

  always_comb begin
    unique case (phase)
      PH_START_A, PH_START_B, PH_STOP_A, PH_STOP_B, PH_R_LOW, PH_R_HIGH: units = s2;
      PH_ACK_A, PH_ACK_B: units = 9'd1;
      default: units = s1;
    endcase
  end

  // Output register with a skid entry, so the engine can take one more tick
  // while a result waits and stops once the skid entry is full.
  res_t skid;
  logic skid_valid;
  assign in_ready = !skid_valid;
  assign step     = in_valid && in_ready;

  always_comb begin
    phase_next = phase; bit_count_next = bit_count; shift_reg_next = shift_reg;
    unit_count_next = unit_count; delay_count_next = delay_count;
    poll_count_next = poll_count; scl_reg_next = scl_reg; sda_reg_next = sda_reg;
    read_ack_mode_next = read_ack_mode; fail_flag_next = fail_flag;
    sda_oe_next = sda_oe; rx_hold_next = rx_hold; done = 1'b0; elapsed = 1'b0;
    if (phase != PH_IDLE && phase != PH_ACK_POLL) begin
      unit_count_next = uc_inc;
      if (uc_inc >= tpu) begin
        unit_count_next = 10'd0;
        delay_count_next = dc_inc;
        if (dc_inc >= units) begin
          delay_count_next = 9'd0;
          elapsed = 1'b1;
        end
      end
    end
    if (elapsed) begin
      unit_count_next = 10'd0;
      delay_count_next = 9'd0;
    end
    unique case (phase)
      PH_IDLE: begin
        if (in_data.cmd_start) begin
          sda_oe_next = 1'b1; sda_reg_next = 1'b1; scl_reg_next = 1'b1;
          phase_next = PH_START_A;
        end else if (in_data.cmd_stop) begin
          sda_oe_next = 1'b1; scl_reg_next = 1'b0; sda_reg_next = 1'b0;
          phase_next = PH_STOP_A;
        end else if (in_data.cmd_write) begin
          sda_oe_next = 1'b1; scl_reg_next = 1'b0; shift_reg_next = in_data.tx_byte;
          bit_count_next = 4'd0;
          sda_reg_next = |(in_data.tx_byte & MSB_MASK); phase_next = PH_W_LOW;
        end else if (in_data.cmd_read) begin
          sda_oe_next = 1'b0; scl_reg_next = 1'b0; shift_reg_next = 8'd0;
          bit_count_next = 4'd0; read_ack_mode_next = in_data.read_ack;
          phase_next = PH_R_LOW;
        end
        if (phase_next != PH_IDLE) begin
          unit_count_next = 10'd0; delay_count_next = 9'd0;
        end
      end
      PH_START_A: if (elapsed) begin sda_reg_next = 1'b0; phase_next = PH_START_B; end
      PH_START_B: if (elapsed) begin
        scl_reg_next = 1'b0; phase_next = PH_IDLE; done = 1'b1;
      end
      PH_STOP_A: if (elapsed) begin
        scl_reg_next = 1'b1; sda_reg_next = 1'b1; phase_next = PH_STOP_B;
      end
      PH_STOP_B: if (elapsed) begin phase_next = PH_IDLE; done = 1'b1; end
      PH_W_LOW: if (elapsed) begin scl_reg_next = 1'b1; phase_next = PH_W_HIGH; end
      PH_W_HIGH: if (elapsed) begin scl_reg_next = 1'b0; phase_next = PH_W_TAIL; end
      PH_W_TAIL: if (elapsed) begin
        bit_count_next = bc_inc;
        shift_reg_next = {shift_reg[6:0], 1'b0};
        if (bc_inc >= 4'd8) begin
          sda_oe_next = 1'b0; sda_reg_next = 1'b1; phase_next = PH_ACK_A;
        end else begin
          sda_reg_next = shift_reg[6]; phase_next = PH_W_LOW;
        end
      end
      PH_ACK_A: if (elapsed) begin scl_reg_next = 1'b1; phase_next = PH_ACK_B; end
      PH_ACK_B: if (elapsed) begin poll_count_next = 8'd0; phase_next = PH_ACK_POLL; end
      PH_ACK_POLL: begin
        if (!in_data.sda_sample) begin
          scl_reg_next = 1'b0; fail_flag_next = 1'b0; phase_next = PH_IDLE;
          done = 1'b1; unit_count_next = 10'd0; delay_count_next = 9'd0;
        end else if (poll_count >= ack_timeout) begin
          fail_flag_next = 1'b1; sda_oe_next = 1'b1; scl_reg_next = 1'b0;
          sda_reg_next = 1'b0; phase_next = PH_STOP_A;
          unit_count_next = 10'd0; delay_count_next = 9'd0;
        end else begin
          poll_count_next = poll_count + 8'd1;
        end
      end
      PH_R_LOW: if (elapsed) begin scl_reg_next = 1'b1; phase_next = PH_R_HIGH; end
      PH_R_HIGH: if (elapsed) begin
        shift_reg_next = sh_rd; bit_count_next = bc_inc; scl_reg_next = 1'b0;
        if (bc_inc >= 4'd8) begin
          rx_hold_next = sh_rd; sda_oe_next = 1'b1;
          sda_reg_next = !read_ack_mode; phase_next = PH_RA_LOW;
        end else begin
          phase_next = PH_R_LOW;
        end
      end
      PH_RA_LOW: if (elapsed) begin scl_reg_next = 1'b1; phase_next = PH_RA_HIGH; end
      PH_RA_HIGH: if (elapsed) begin
        scl_reg_next = 1'b0; phase_next = PH_IDLE; done = 1'b1;
      end
      default: begin
        phase_next = PH_IDLE; unit_count_next = 10'd0; delay_count_next = 9'd0;
      end
    endcase
    res.scl_level  = scl_reg_next;
    res.sda_level  = sda_reg_next;
    res.sda_enable = sda_oe_next;
    res.busy_res   = (phase_next != PH_IDLE);
    res.done_res   = done;
    res.rx_byte    = rx_hold_next;
    res.ack_failed = fail_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; bit_count <= 4'd0; shift_reg <= 8'd0;
      unit_count <= 10'd0; delay_count <= 9'd0; poll_count <= 8'd0;
      scl_reg <= 1'b1; sda_reg <= 1'b1; read_ack_mode <= 1'b0;
      fail_flag <= 1'b0; sda_oe <= 1'b1; rx_hold <= 8'd0;
      out_valid <= 1'b0; skid_valid <= 1'b0;
    end else begin
      if (step) begin
        phase <= phase_next; bit_count <= bit_count_next;
        shift_reg <= shift_reg_next; unit_count <= unit_count_next;
        delay_count <= delay_count_next; poll_count <= poll_count_next;
        scl_reg <= scl_reg_next; sda_reg <= sda_reg_next;
        read_ack_mode <= read_ack_mode_next; fail_flag <= fail_flag_next;
        sda_oe <= sda_oe_next; rx_hold <= rx_hold_next;
      end
      if (!out_valid || out_ready) begin
        if (skid_valid) begin
          out_data <= skid; out_valid <= 1'b1; skid_valid <= 1'b0;
        end else begin
          out_data <= res; out_valid <= step;
        end
      end else if (step) begin
        skid <= res; skid_valid <= 1'b1;
      end
    end
  end
endmodule

FILE: tb/i2c_master_byte_engine_tb.sv
// Self-checking testbench for the I2C master byte engine: drives tick transfers and
// configuration writes, predicts every result transfer and compares it field by field.
// Depends on i2cmbe_pkg and the i2c_master_byte_engine top level.

module i2c_master_byte_engine_tb;
  import i2cmbe_pkg::*;

  // Phases of the bit engine as the predictor tracks them.
  typedef enum int {
    ST_IDLE, ST_START_A, ST_START_B, ST_STOP_A, ST_STOP_B,
    ST_W_LOW, ST_W_HIGH, ST_W_TAIL, ST_ACK_A, ST_ACK_B, ST_ACK_POLL,
    ST_R_LOW, ST_R_HIGH, ST_RA_LOW, ST_RA_HIGH
  } eng_state_t;

  // Scoreboard: a cycle-exact model of the engine plus the queue of results it
  // has predicted and that the block has not delivered yet.
  class bus_scoreboard;
    logic [9:0] tpu_cfg;
    logic [7:0] speed_cfg, timeout_cfg;
    eng_state_t st;
    logic [3:0] bits_done;
    logic [7:0] shifter;
    logic [9:0] unit_cnt;
    logic [8:0] dly_cnt;
    logic [7:0] polls;
    logic       scl, sda, sda_oe, ack_mode, failed;
    logic [7:0] rx_hold;
    res_t       pending_res[$];
    int         mismatches;

    function new();
      tpu_cfg = 10'd50; speed_cfg = 8'd2; timeout_cfg = 8'd250;
      st = ST_IDLE; bits_done = 0; shifter = 0; unit_cnt = 0; dly_cnt = 0;
      polls = 0; scl = 1; sda = 1; sda_oe = 1; ack_mode = 0; failed = 0;
      rx_hold = 0; mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [9:0] val);
      case (idx)
        REG_TPU:     tpu_cfg = val;
        REG_SPEED:   speed_cfg = val[7:0];
        REG_TIMEOUT: timeout_cfg = val[7:0];
        default: ;
      endcase
    endfunction

    function bit busy();
      return st != ST_IDLE;
    endfunction

    // One tick of the unit/delay counters; true once 'units' units have passed.
    function bit units_elapsed(int unsigned units);
      int unsigned tp;
      tp = (tpu_cfg == 0) ? 1 : tpu_cfg;
      if (units == 0) units = 1;
      unit_cnt = unit_cnt + 10'd1;
      if (unit_cnt >= tp) begin
        unit_cnt = 0;
        dly_cnt = dly_cnt + 9'd1;
        if (dly_cnt >= units) begin
          dly_cnt = 0;
          return 1;
        end
      end
      return 0;
    endfunction

    function void enter(eng_state_t s);
      st = s; unit_cnt = 0; dly_cnt = 0;
    endfunction

    // An input transfer was accepted: advance the model by one tick.
    function void note_tick(logic [2:0] req, logic [7:0] tx, logic sda_in);
      int unsigned s;
      bit done;
      res_t r;
      s = (speed_cfg == 0) ? 1 : speed_cfg;
      done = 0;
      case (st)
        ST_IDLE: begin
          if (req == REQ_START) begin
            sda_oe = 1; sda = 1; scl = 1; enter(ST_START_A);
          end else if (req == REQ_STOP) begin
            sda_oe = 1; scl = 0; sda = 0; enter(ST_STOP_A);
          end else if (req == REQ_WRITE) begin
            sda_oe = 1; scl = 0; shifter = tx; bits_done = 0;
            sda = |(shifter & MSB_MASK); enter(ST_W_LOW);
          end else if (req == REQ_RDACK || req == REQ_RDNAK) begin
            sda_oe = 0; scl = 0; shifter = 0; bits_done = 0;
            ack_mode = (req == REQ_RDACK); enter(ST_R_LOW);
          end
        end
        ST_START_A: if (units_elapsed(2 * s)) begin
          sda = 0; enter(ST_START_B);
        end
        ST_START_B: if (units_elapsed(2 * s)) begin
          scl = 0; enter(ST_IDLE); done = 1;
        end
        ST_STOP_A: if (units_elapsed(2 * s)) begin
          scl = 1; sda = 1; enter(ST_STOP_B);
        end
        ST_STOP_B: if (units_elapsed(2 * s)) begin
          enter(ST_IDLE); done = 1;
        end
        ST_W_LOW: if (units_elapsed(s)) begin
          scl = 1; enter(ST_W_HIGH);
        end
        ST_W_HIGH: if (units_elapsed(s)) begin
          scl = 0; enter(ST_W_TAIL);
        end
        ST_W_TAIL: if (units_elapsed(s)) begin
          bits_done = bits_done + 4'd1;
          shifter = shifter << 1;
          if (bits_done >= 8) begin
            sda_oe = 0; sda = 1; enter(ST_ACK_A);
          end else begin
            sda = |(shifter & MSB_MASK); enter(ST_W_LOW);
          end
        end
        ST_ACK_A: if (units_elapsed(1)) begin
          scl = 1; enter(ST_ACK_B);
        end
        ST_ACK_B: if (units_elapsed(1)) begin
          polls = 0; enter(ST_ACK_POLL);
        end
        ST_ACK_POLL: begin
          if (!sda_in) begin
            scl = 0; failed = 0; enter(ST_IDLE); done = 1;
          end else if (polls >= timeout_cfg) begin
            // No acknowledge in time: flag it and run a stop on our own.
            failed = 1; sda_oe = 1; scl = 0; sda = 0; enter(ST_STOP_A);
          end else begin
            polls = polls + 8'd1;
          end
        end
        ST_R_LOW: if (units_elapsed(2 * s)) begin
          scl = 1; enter(ST_R_HIGH);
        end
        ST_R_HIGH: if (units_elapsed(2 * s)) begin
          shifter = {shifter[6:0], sda_in};
          bits_done = bits_done + 4'd1;
          scl = 0;
          if (bits_done >= 8) begin
            rx_hold = shifter; sda_oe = 1; sda = !ack_mode; enter(ST_RA_LOW);
          end else begin
            enter(ST_R_LOW);
          end
        end
        ST_RA_LOW: if (units_elapsed(s)) begin
          scl = 1; enter(ST_RA_HIGH);
        end
        ST_RA_HIGH: if (units_elapsed(s)) begin
          scl = 0; enter(ST_IDLE); done = 1;
        end
        default: enter(ST_IDLE);
      endcase
      r.scl_level = scl; r.sda_level = sda; r.sda_enable = sda_oe;
      r.busy_res = (st != ST_IDLE); r.done_res = done;
      r.rx_byte = rx_hold; r.ack_failed = failed;
      pending_res.push_back(r);
    endfunction

    function void compare(string field, int exp_v, int act_v);
      if (exp_v != act_v) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch in %s: expected %0h, got %0h", field, exp_v, act_v);
      end
    endfunction

    // A result transfer was accepted: compare it with the oldest prediction.
    function void check_result(logic [15:0] d);
      res_t e;
      if (pending_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %h", d);
        return;
      end
      e = pending_res.pop_front();
      compare("scl_level", e.scl_level, d[0]);
      compare("sda_level", e.sda_level, d[1]);
      compare("sda_enable", e.sda_enable, d[2]);
      compare("busy_res", e.busy_res, d[3]);
      compare("done_res", e.done_res, d[4]);
      compare("rx_byte", e.rx_byte, d[12:5]);
      compare("ack_failed", e.ack_failed, d[13]);
      compare("padding", 0, d[15:14]);
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [9:0]  cfg_data = '0;

  bus_scoreboard sb = new();
  int  ticks_sent = 0;
  int  results_seen = 0;
  bit  no_idle = 0;  // when set, neither side inserts random gaps

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  i2c_master_byte_engine i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Receiver side: random stalls per transfer, plus one long hold-off after a
  // few hundred results so that the internal queue fills and s_tready drops.
  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        sb.check_result(m_tdata);
        results_seen++;
        if (results_seen == 300) hold_left = 500;
        stall_left = no_idle ? 0 : $urandom_range(0, 14);
      end
      if (rst) begin
        m_tready <= 0;
      end else if (hold_left > 0) begin
        hold_left--;
        m_tready <= 0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  // Offer one tick transfer, wait for it to be taken, then may idle for a random gap.
  // Valid stays high when no gap follows, so back-to-back transfers keep it up.
  task automatic send_tick(logic [2:0] req, logic [7:0] tx, logic sda_in);
    int gap;
    s_tvalid <= 1;
    s_tdata <= {4'b0, sda_in, tx, req};
    do @(posedge clk); while (!s_tready);
    sb.note_tick(req, tx, sda_in);
    ticks_sent++;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Keep ticking the engine until the model says the command is over. Now and
  // then a request is offered while busy; the engine has to ignore it.
  task automatic finish_command(int sda_high_pct);
    logic [2:0] req;
    while (sb.busy()) begin
      req = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : REQ_NONE;
      send_tick(req, 8'($urandom), $urandom_range(0, 99) < sda_high_pct);
    end
  endtask

  task automatic run_command(logic [2:0] req, logic [7:0] tx, int sda_high_pct);
    send_tick(req, tx, $urandom_range(0, 99) < sda_high_pct);
    finish_command(sda_high_pct);
  endtask

  // Registers change only with the engine idle and every result delivered.
  task automatic write_cfg(logic [1:0] idx, logic [9:0] val);
    s_tvalid <= 0;
    do @(posedge clk); while (sb.pending_res.size() != 0);
    repeat (8) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 0;
  endtask

  task automatic set_timing(logic [9:0] tpu, logic [7:0] spd, logic [7:0] tmo);
    write_cfg(REG_TPU, tpu);
    write_cfg(REG_SPEED, {2'b0, spd});
    write_cfg(REG_TIMEOUT, {2'b0, tmo});
  endtask

  initial begin : stimulus
    logic [9:0] tpu_set[7] = '{10'd1, 10'd2, 10'd0, 10'd3, 10'd5, 10'd1, 10'd1};
    logic [7:0] spd_set[7] = '{8'd1, 8'd1, 8'd0, 8'd2, 8'd1, 8'd4, 8'd3};
    logic [7:0] tmo_set[7] = '{8'd0, 8'd5, 8'd255, 8'd20, 8'd2, 8'd1, 8'd10};
    int pct_choice[3] = '{3, 50, 97};
    int k;
    int n_cmds;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed part. One start at the reset timing first, then fast timing
    // for the byte commands.
    run_command(REQ_START, 8'h00, 50);
    set_timing(10'd1, 8'd1, 8'd3);
    run_command(REQ_WRITE, 8'h00, 0);     // acknowledged at once
    run_command(REQ_WRITE, 8'hFF, 100);   // no acknowledge: timeout, forced stop
    run_command(REQ_WRITE, 8'hA5, 60);
    run_command(REQ_RDACK, 8'h00, 100);   // reads all ones
    run_command(REQ_RDNAK, 8'hFF, 0);     // reads all zeros
    run_command(REQ_RDACK, 8'h3C, 50);
    run_command(REQ_STOP, 8'h00, 50);
    run_command(3'd6, 8'h12, 50);         // unused codes are ignored
    run_command(3'd7, 8'h34, 50);
    run_command(REQ_NONE, 8'h56, 50);
    set_timing(10'd1, 8'd1, 8'd0);
    run_command(REQ_WRITE, 8'h5A, 100);   // zero timeout fails on the first poll

    // Random part: walk through the timing settings, zero values included,
    // a few commands at a time until enough ticks have been sent.
    n_cmds = 4;
    for (int p = 0; ticks_sent < 1550; p++) begin
      k = p % 7;
      no_idle = (p % 3 == 0);
      set_timing(tpu_set[k], spd_set[k], tmo_set[k]);
      for (int c = 0; c < n_cmds && ticks_sent < 1550; c++)
        run_command(3'($urandom_range(0, 7)), 8'($urandom),
                    pct_choice[$urandom_range(0, 2)]);
    end
    s_tvalid <= 0;
    no_idle = 0;

    do @(posedge clk); while (sb.pending_res.size() != 0);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_res.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin : watchdog
    #40000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/i2cmbe_pkg.sv
hdl/i2cmbe_front.sv
hdl/i2cmbe_fifo.sv
hdl/i2cmbe_back.sv
hdl/i2c_master_byte_engine.sv
tb/i2c_master_byte_engine_tb.sv
